// ===== src/lsc_pkg.sv =====
// Shared types, constants and helpers for the LRU slot cache.
`default_nettype none
package lsc_pkg;

  // Cache geometry
  localparam int SLOTS       = 8;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KEY_W       = 32;
  localparam int USE_W       = 8;
  localparam int LIMIT_W     = 9;
  localparam int MAX_RESULTS = 9;
  localparam int FLUSH_CNT_W = $clog2(MAX_RESULTS + 1);

  typedef logic [SLOT_W-1:0] slot_t;

  // Request kinds
  typedef enum logic [1:0] {
    ACT_LOOKUP  = 2'd0,
    ACT_COMMIT  = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_FLUSH   = 2'd3
  } act_t;

  // Result event codes
  typedef enum logic [2:0] {
    EV_HIT       = 3'd0,
    EV_FILL      = 3'd1,
    EV_WRITEBACK = 3'd2,
    EV_FREED     = 3'd3,
    EV_DONE      = 3'd4,
    EV_NOCUR     = 3'd5
  } ev_t;

  // Recency ring update: one next-link and one prev-link write per cycle
  typedef struct packed {
    logic  next_we;
    slot_t next_addr;
    slot_t next_data;
    logic  prev_we;
    slot_t prev_addr;
    slot_t prev_data;
  } ring_wr_t;

  // Slot store update, all at one slot address
  typedef struct packed {
    slot_t             addr;
    logic              key_we;
    logic [KEY_W-1:0]  key;
    logic              valid_we;
    logic              valid_val;
    logic              uses_we;
    logic [USE_W-1:0]  uses_val;
    logic              clr_all;
  } store_wr_t;

  // Slot index as reported: low three bits
  function automatic logic [2:0] slot_field(input slot_t s);
    logic [SLOT_W+2:0] ext;
    ext = {3'b000, s};
    return ext[2:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/lru_slot_cache_with_writeback_core.sv =====
// Top level: request sequencer, compare logic and result register.
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid / in_tready | tuser: action; tdata: key
//  out_    | out | out_tvalid/out_tready | tuser: event_res; tdata: slot,
//          |     |                       |   entry_key, use_count; tlast: last
//  cfg_    | in  | cfg_we                | cfg_wdata: volley_limit
//
// One request at a time; in_tready is high only while the sequencer is idle.
// Lookup: one ring slot searched per cycle (up to 8) on the key compare; a hit off the head
// adds states MTF1-MTF3 to relink, a miss adds a tail-check state, then the result beat.
// Commit/release: 1-2 result beats. Flush: walks every ring slot, then a done beat.
// Each result beat waits for room in the single output register.
// Reset (rst_n low, synchronous) empties the cache and relinks the ring.
`default_nettype none
module lru_slot_cache_with_writeback_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // [1:0] action
  input  wire logic [31:0] in_tdata,   // [31:0] key
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [2:0]       out_tuser,  // [2:0] event_res
  output logic [47:0]      out_tdata,  // [2:0] slot, [34:3] entry_key,
                                       // [42:35] use_count, [47:43] zero
  output logic             out_tlast,  // last
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata   // volley_limit
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MTF1,
    ST_MTF2,
    ST_MTF3,
    ST_HIT_OUT,
    ST_MISS_WB,
    ST_MISS_FILL,
    ST_COMMIT,
    ST_FREE,
    ST_NOCUR,
    ST_FLUSH_WALK,
    ST_FLUSH_DONE
  } state_t;

  state_t                          state_r;
  logic [lsc_pkg::KEY_W-1:0]       key_r;
  lsc_pkg::slot_t                  sel_r;
  lsc_pkg::slot_t                  head_r;
  lsc_pkg::slot_t                  cur_r;
  logic                            cur_valid_r;
  lsc_pkg::slot_t                  p2_r;
  logic [lsc_pkg::FLUSH_CNT_W-1:0] wbn_r;
  logic signed [lsc_pkg::LIMIT_W-1:0] limit_r;

  logic                            out_valid_r;
  lsc_pkg::ev_t                    out_ev_r;
  logic [2:0]                      out_slot_r;
  logic [lsc_pkg::KEY_W-1:0]       out_key_r;
  logic [lsc_pkg::USE_W-1:0]       out_uses_r;
  logic                            out_last_r;

  lsc_pkg::slot_t                  next_rd;
  lsc_pkg::slot_t                  prev_rd;
  lsc_pkg::slot_t                  prev_raddr;
  logic [lsc_pkg::KEY_W-1:0]       rd_key;
  logic                            rd_valid;
  logic [lsc_pkg::USE_W-1:0]       rd_uses;
  lsc_pkg::ring_wr_t               ring_wr;
  lsc_pkg::store_wr_t              store_wr;

  logic                            emit_ok;
  logic                            out_load;
  logic                            key_match;
  logic [lsc_pkg::USE_W:0]         cnt;
  logic                            cnt_ge;
  logic                            lim_zero;
  logic                            in_beat;
  lsc_pkg::act_t                   in_act;

  lsc_ring u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .next_raddr (sel_r),
    .next_rdata (next_rd),
    .prev_raddr (prev_raddr),
    .prev_rdata (prev_rd),
    .wr         (ring_wr)
  );

  lsc_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (sel_r),
    .rd_key   (rd_key),
    .rd_valid (rd_valid),
    .rd_uses  (rd_uses),
    .wr       (store_wr)
  );

  // Ports
  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign in_act     = lsc_pkg::act_t'(in_tuser);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tdata  = {5'b00000, out_uses_r, out_key_r, out_slot_r};
  assign out_tlast  = out_last_r;

  // Room for a result beat this cycle
  assign emit_ok = !out_valid_r || out_tready;

  // Compare logic: key match during search, count vs limit on commit
  assign key_match = rd_valid && (rd_key == key_r);
  assign cnt       = {1'b0, rd_uses} + (lsc_pkg::USE_W + 1)'(1);
  assign cnt_ge    = $signed({1'b0, cnt}) >= $signed({limit_r[lsc_pkg::LIMIT_W-1], limit_r});
  assign lim_zero  = (limit_r == '0);

  // Prev link is read at the hit slot while unlinking, else at the head
  assign prev_raddr = (state_r == ST_MTF1) ? sel_r : head_r;

  // A result beat enters the output register this cycle
  always_comb begin
    out_load = 1'b0;
    unique case (state_r)
      ST_HIT_OUT, ST_MISS_FILL, ST_COMMIT, ST_FREE, ST_NOCUR, ST_FLUSH_DONE: begin
        out_load = emit_ok;
      end
      ST_MISS_WB: begin
        out_load = emit_ok && rd_valid;
      end
      ST_FLUSH_WALK: begin
        out_load = emit_ok && rd_valid &&
                   (wbn_r < lsc_pkg::FLUSH_CNT_W'(lsc_pkg::MAX_RESULTS - 1));
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Ring and store writes
  always_comb begin
    ring_wr  = '0;
    store_wr = '0;
    store_wr.addr = sel_r;
    store_wr.key  = key_r;
    unique case (state_r)
      ST_MTF1: begin
        // unlink the hit slot
        ring_wr.next_we   = 1'b1;
        ring_wr.next_addr = prev_rd;
        ring_wr.next_data = next_rd;
        ring_wr.prev_we   = 1'b1;
        ring_wr.prev_addr = next_rd;
        ring_wr.prev_data = prev_rd;
      end
      ST_MTF2: begin
        // splice in ahead of the head
        ring_wr.prev_we   = 1'b1;
        ring_wr.prev_addr = head_r;
        ring_wr.prev_data = sel_r;
        ring_wr.next_we   = 1'b1;
        ring_wr.next_addr = prev_rd;
        ring_wr.next_data = sel_r;
      end
      ST_MTF3: begin
        ring_wr.prev_we   = 1'b1;
        ring_wr.prev_addr = sel_r;
        ring_wr.prev_data = p2_r;
        ring_wr.next_we   = 1'b1;
        ring_wr.next_addr = sel_r;
        ring_wr.next_data = head_r;
      end
      ST_MISS_FILL: begin
        store_wr.key_we    = emit_ok;
        store_wr.valid_we  = emit_ok;
        store_wr.valid_val = 1'b1;
        store_wr.uses_we   = emit_ok;
        store_wr.uses_val  = '0;
      end
      ST_COMMIT: begin
        store_wr.uses_we  = emit_ok;
        store_wr.uses_val = cnt_ge ? '0 : cnt[lsc_pkg::USE_W-1:0];
      end
      ST_FREE: begin
        store_wr.valid_we  = emit_ok;
        store_wr.valid_val = 1'b0;
      end
      ST_FLUSH_DONE: begin
        store_wr.clr_all = emit_ok;
      end
      default: begin
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '1;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      sel_r       <= '0;
      wbn_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            key_r <= in_tdata[lsc_pkg::KEY_W-1:0];
            unique case (in_act)
              lsc_pkg::ACT_LOOKUP: begin
                sel_r   <= head_r;
                state_r <= ST_SEARCH;
              end
              lsc_pkg::ACT_COMMIT: begin
                sel_r   <= cur_r;
                state_r <= cur_valid_r ? ST_COMMIT : ST_NOCUR;
              end
              lsc_pkg::ACT_RELEASE: begin
                sel_r   <= cur_r;
                state_r <= cur_valid_r ? ST_FREE : ST_NOCUR;
              end
              lsc_pkg::ACT_FLUSH: begin
                sel_r   <= head_r;
                wbn_r   <= '0;
                state_r <= ST_FLUSH_WALK;
              end
            endcase
          end
        end
        // one ring slot per cycle from the head
        ST_SEARCH: begin
          priority if (key_match) begin
            state_r <= (sel_r == head_r) ? ST_HIT_OUT : ST_MTF1;
          end else if (next_rd == head_r) begin
            sel_r   <= prev_rd;
            state_r <= ST_MISS_WB;
          end else begin
            sel_r <= next_rd;
          end
        end
        ST_MTF1: state_r <= ST_MTF2;
        ST_MTF2: begin
          p2_r    <= prev_rd;
          state_r <= ST_MTF3;
        end
        ST_MTF3: state_r <= ST_HIT_OUT;
        ST_HIT_OUT: begin
          if (emit_ok) begin
            out_ev_r    <= lsc_pkg::EV_HIT;
            out_slot_r  <= lsc_pkg::slot_field(sel_r);
            out_key_r   <= rd_key;
            out_uses_r  <= rd_uses;
            out_last_r  <= 1'b1;
            head_r      <= sel_r;
            cur_r       <= sel_r;
            cur_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        // evict the tail slot if it holds a key
        ST_MISS_WB: begin
          priority if (!rd_valid) begin
            state_r <= ST_MISS_FILL;
          end else if (emit_ok) begin
            out_ev_r    <= lsc_pkg::EV_WRITEBACK;
            out_slot_r  <= lsc_pkg::slot_field(sel_r);
            out_key_r   <= rd_key;
            out_uses_r  <= '0;
            out_last_r  <= 1'b0;
            state_r     <= ST_MISS_FILL;
          end
        end
        ST_MISS_FILL: begin
          if (emit_ok) begin
            out_ev_r    <= lsc_pkg::EV_FILL;
            out_slot_r  <= lsc_pkg::slot_field(sel_r);
            out_key_r   <= key_r;
            out_uses_r  <= '0;
            out_last_r  <= 1'b1;
            head_r      <= sel_r;
            cur_r       <= sel_r;
            cur_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        // bump count; writeback at limit, free on zero limit
        ST_COMMIT: begin
          if (emit_ok) begin
            out_slot_r  <= lsc_pkg::slot_field(sel_r);
            out_key_r   <= rd_key;
            if (cnt_ge) begin
              out_ev_r   <= lsc_pkg::EV_WRITEBACK;
              out_uses_r <= '0;
              out_last_r <= !lim_zero;
            end else begin
              out_ev_r   <= lsc_pkg::EV_DONE;
              out_uses_r <= cnt[lsc_pkg::USE_W-1:0];
              out_last_r <= 1'b1;
            end
            if (lim_zero) begin
              state_r <= ST_FREE;
            end else begin
              cur_valid_r <= 1'b0;
              state_r     <= ST_IDLE;
            end
          end
        end
        ST_FREE: begin
          if (emit_ok) begin
            out_ev_r    <= lsc_pkg::EV_FREED;
            out_slot_r  <= lsc_pkg::slot_field(sel_r);
            out_key_r   <= rd_key;
            out_uses_r  <= rd_uses;
            out_last_r  <= 1'b1;
            head_r      <= next_rd;
            cur_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        ST_NOCUR: begin
          if (emit_ok) begin
            out_ev_r    <= lsc_pkg::EV_NOCUR;
            out_slot_r  <= '0;
            out_key_r   <= '0;
            out_uses_r  <= '0;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        // walk the ring, one writeback beat per valid slot
        ST_FLUSH_WALK: begin
          if (rd_valid && (wbn_r < lsc_pkg::FLUSH_CNT_W'(lsc_pkg::MAX_RESULTS - 1))) begin
            if (emit_ok) begin
              out_ev_r    <= lsc_pkg::EV_WRITEBACK;
              out_slot_r  <= lsc_pkg::slot_field(sel_r);
              out_key_r   <= rd_key;
              out_uses_r  <= '0;
              out_last_r  <= 1'b0;
              wbn_r       <= wbn_r + lsc_pkg::FLUSH_CNT_W'(1);
              sel_r       <= next_rd;
              if (next_rd == head_r) state_r <= ST_FLUSH_DONE;
            end
          end else begin
            sel_r <= next_rd;
            if (next_rd == head_r) state_r <= ST_FLUSH_DONE;
          end
        end
        ST_FLUSH_DONE: begin
          if (emit_ok) begin
            out_ev_r    <= lsc_pkg::EV_DONE;
            out_slot_r  <= lsc_pkg::slot_field(head_r);
            out_key_r   <= '0;
            out_uses_r  <= '0;
            out_last_r  <= 1'b1;
            cur_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // A pending hit or fill names the slot that is now head and current
  a_fill_is_current: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_ev_r == lsc_pkg::EV_HIT || out_ev_r == lsc_pkg::EV_FILL))
      |-> (cur_valid_r && lsc_pkg::slot_field(cur_r) == out_slot_r && cur_r == head_r))
    else $error("hit/fill result does not match current slot");

  // A result that is not the last one leaves the sequencer busy
  a_more_to_come: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> !in_tready)
    else $error("non-final result while idle");

  // A taken request keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready)
    else $error("ready right after accepting a request");

endmodule
`default_nettype wire

// ===== src/lsc_ring.sv =====
// Circular recency ring: next/prev link arrays with one read port each.
`default_nettype none
module lsc_ring (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lsc_pkg::slot_t   next_raddr,
  output lsc_pkg::slot_t        next_rdata,
  input  wire lsc_pkg::slot_t   prev_raddr,
  output lsc_pkg::slot_t        prev_rdata,
  input  wire lsc_pkg::ring_wr_t wr
);

  lsc_pkg::slot_t next_r [lsc_pkg::SLOTS];
  lsc_pkg::slot_t prev_r [lsc_pkg::SLOTS];

  assign next_rdata = next_r[next_raddr];
  assign prev_rdata = prev_r[prev_raddr];

  // Reset links each slot to its neighbors; then one write per array per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lsc_pkg::SLOTS; i++) begin
        next_r[i] <= lsc_pkg::SLOT_W'((i + 1) % lsc_pkg::SLOTS);
        prev_r[i] <= lsc_pkg::SLOT_W'((i + lsc_pkg::SLOTS - 1) % lsc_pkg::SLOTS);
      end
    end else begin
      if (wr.next_we) next_r[wr.next_addr] <= wr.next_data;
      if (wr.prev_we) prev_r[wr.prev_addr] <= wr.prev_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/lsc_store.sv =====
// Per-slot key, valid flag and use count, read and written at one slot; flush clears flags and counts.
`default_nettype none
module lsc_store (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lsc_pkg::slot_t              rd_addr,
  output logic [lsc_pkg::KEY_W-1:0]        rd_key,
  output logic                             rd_valid,
  output logic [lsc_pkg::USE_W-1:0]        rd_uses,
  input  wire lsc_pkg::store_wr_t          wr
);

  logic [lsc_pkg::KEY_W-1:0] key_r   [lsc_pkg::SLOTS];
  logic [lsc_pkg::SLOTS-1:0] valid_r;
  logic [lsc_pkg::USE_W-1:0] uses_r  [lsc_pkg::SLOTS];

  assign rd_key   = key_r[rd_addr];
  assign rd_valid = valid_r[rd_addr];
  assign rd_uses  = uses_r[rd_addr];

  // Keys hold no reset; they are only looked at behind a valid flag
  always_ff @(posedge clk) begin
    if (wr.key_we) key_r[wr.addr] <= wr.key;
  end

  // Valid flags and counts; flush clears all at once
  always_ff @(posedge clk) begin
    if (!rst_n || wr.clr_all) begin
      valid_r <= '0;
      for (int i = 0; i < lsc_pkg::SLOTS; i++) uses_r[i] <= '0;
    end else begin
      if (wr.valid_we) valid_r[wr.addr] <= wr.valid_val;
      if (wr.uses_we)  uses_r[wr.addr]  <= wr.uses_val;
    end
  end

endmodule
`default_nettype wire
